>>> design/ets_pkg.sv
// shared types, command and status codes for the event timer slot table
package ets_pkg;

	localparam int TIME_W = 48;
	localparam int ID_W   = 8;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_HANDLE = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] due;
	} entry_t;

endpackage

>>> design/ets_sub.sv
// shared 48-bit subtract and compare unit
module ets_sub
	import ets_pkg::*;
(
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	output logic [TIME_W-1:0] diff,
	output logic              borrow
);

	logic [TIME_W:0] wide;

	assign wide   = {1'b0, a} - {1'b0, b};
	assign diff   = wide[TIME_W-1:0];
	assign borrow = wide[TIME_W];

endmodule

>>> design/ets_mem.sv
// slot table memory, one write port and one registered read port
module ets_mem
	import ets_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

>>> design/event_timer_slot_table_core.sv
// top level: command sequencer that scans the slot table through one subtract unit
//
// A command word (cmd, event_id, event_time) is taken at a rising edge where
// start is high and busy is low. busy stays high while the command runs. The
// result word (status, next_time, fired_id) is shown for exactly one cycle
// with done high; the receiver cannot stall it and must take it then.
// Commands that walk the table go one slot per cycle, with reads through the
// single memory read port and the shared subtract unit:
//   clear: writes every slot to zero, then done
//   insert, remove, adjust: stop at the first hit (a free slot, or the id)
//   query: scans the whole table
//   handle: one extra read of the chosen slot first; done with empty if stale
//   unused codes: done in the cycle after start
// The next command can be taken in the cycle that done is high.
// After reset the block runs a clearing pass over the table, with busy high,
// before it takes the first command.
module event_timer_slot_table_core
	import ets_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ID_W-1:0]   event_id,
	input  logic [TIME_W-1:0] event_time,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [TIME_W-1:0] next_time,
	output logic [ID_W-1:0]   fired_id
);

	localparam int IDX_W = $clog2(SLOTS);

	typedef enum logic [1:0] {S_IDLE, S_CLR, S_HCHK, S_SCAN} state_t;

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] time_q;
	logic [IDX_W:0]    ra_q;
	logic [IDX_W-1:0]  ev_q;
	logic              pend_q;
	logic [TIME_W-1:0] acc_q;
	logic [IDX_W-1:0]  best_q;
	logic              found_q;
	logic [IDX_W-1:0]  chosen_q;
	logic [ID_W-1:0]   fired_q;
	logic              rsp_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [TIME_W-1:0] next_time_q;
	logic [ID_W-1:0]   fired_id_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;
	logic [IDX_W-1:0]  raddr;
	entry_t            rd;
	logic [TIME_W-1:0] diff;
	logic              borrow;

	logic              last;
	logic              issue;
	logic              id_hit;
	logic              take;
	logic              fin_found;
	logic [TIME_W-1:0] fin_time;
	logic [IDX_W-1:0]  fin_idx;

	ets_mem #(.DEPTH(SLOTS)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	ets_sub u_sub (
		.a      (rd.due),
		.b      (acc_q),
		.diff   (diff),
		.borrow (borrow)
	);

	assign last      = (ev_q == IDX_W'(SLOTS - 1));
	assign issue     = (ra_q < (IDX_W + 1)'(SLOTS));
	assign id_hit    = rd.valid && (rd.id == id_q);
	assign take      = rd.valid && (!found_q || borrow);
	assign fin_found = found_q || take;
	assign fin_time  = take ? rd.due : acc_q;
	assign fin_idx   = take ? ev_q : best_q;
	assign raddr     = (state_q == S_IDLE) ? chosen_q : ra_q[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = ev_q;
		wdata = rd;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = ra_q[IDX_W-1:0];
				wdata = '0;
			end
			S_SCAN: begin
				if (pend_q) begin
					case (cmd_q)
						CMD_INSERT: begin
							if (!rd.valid) begin
								we          = 1'b1;
								wdata.valid = 1'b1;
								wdata.id    = id_q;
								wdata.due   = time_q;
							end
						end
						CMD_REMOVE: begin
							if (id_hit) begin
								we          = 1'b1;
								wdata.valid = 1'b0;
							end
						end
						CMD_ADJUST: begin
							if (id_hit) begin
								we        = 1'b1;
								wdata.due = time_q;
							end
						end
						CMD_HANDLE: begin
							if (rd.valid) begin
								we          = 1'b1;
								wdata.valid = (ev_q != chosen_q);
								wdata.due   = borrow ? '0 : diff;
							end
						end
						default: begin
							we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cmd_q       <= CMD_CLEAR;
			id_q        <= '0;
			time_q      <= '0;
			ra_q        <= '0;
			ev_q        <= '0;
			pend_q      <= 1'b0;
			acc_q       <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
			fired_q     <= '0;
			rsp_q       <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			next_time_q <= '0;
			fired_id_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						id_q    <= event_id;
						time_q  <= event_time;
						ra_q    <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						case (cmd)
							CMD_CLEAR: begin
								state_q <= S_CLR;
								rsp_q   <= 1'b1;
							end
							CMD_INSERT, CMD_REMOVE, CMD_ADJUST, CMD_QUERY: begin
								state_q <= S_SCAN;
							end
							CMD_HANDLE: begin
								state_q <= S_HCHK;
							end
							default: begin
								done_q      <= 1'b1;
								status_q    <= ST_OK;
								next_time_q <= '0;
								fired_id_q  <= '0;
							end
						endcase
					end
				end
				S_CLR: begin
					ra_q <= ra_q + 1'b1;
					if (ra_q[IDX_W-1:0] == IDX_W'(SLOTS - 1)) begin
						state_q     <= S_IDLE;
						rsp_q       <= 1'b0;
						done_q      <= rsp_q;
						status_q    <= ST_OK;
						next_time_q <= '0;
						fired_id_q  <= '0;
					end
				end
				S_HCHK: begin
					if (!rd.valid) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						status_q    <= ST_EMPTY;
						next_time_q <= '0;
						fired_id_q  <= '0;
					end else begin
						acc_q   <= rd.due;
						fired_q <= rd.id;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ra_q   <= ra_q + 1'b1;
						pend_q <= 1'b1;
						ev_q   <= ra_q[IDX_W-1:0];
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q) begin
						case (cmd_q)
							CMD_INSERT: begin
								if (!rd.valid || last) begin
									state_q     <= S_IDLE;
									done_q      <= 1'b1;
									status_q    <= rd.valid ? ST_FULL : ST_OK;
									next_time_q <= '0;
									fired_id_q  <= '0;
								end
							end
							CMD_REMOVE, CMD_ADJUST: begin
								if (id_hit || last) begin
									state_q     <= S_IDLE;
									done_q      <= 1'b1;
									status_q    <= id_hit ? ST_OK : ST_NOT_FOUND;
									next_time_q <= '0;
									fired_id_q  <= '0;
								end
							end
							CMD_QUERY: begin
								found_q <= fin_found;
								acc_q   <= fin_time;
								best_q  <= fin_idx;
								if (last) begin
									state_q    <= S_IDLE;
									done_q     <= 1'b1;
									fired_id_q <= '0;
									if (fin_found) begin
										status_q    <= ST_OK;
										next_time_q <= fin_time;
										chosen_q    <= fin_idx;
									end else begin
										status_q    <= ST_EMPTY;
										next_time_q <= '0;
									end
								end
							end
							default: begin
								if (last) begin
									state_q     <= S_IDLE;
									done_q      <= 1'b1;
									status_q    <= ST_OK;
									next_time_q <= acc_q;
									fired_id_q  <= fired_q;
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign next_time = next_time_q;
	assign fired_id  = fired_id_q;

`ifndef SYNTH
	a_unused_quick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd > CMD_HANDLE) |=> done)
		else $error("unused code not answered in one cycle");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (next_time == '0) && (fired_id == '0))
		else $error("error word carries payload");

	a_full_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> (cmd_q == CMD_INSERT))
		else $error("full status outside insert");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (ra_q <= (IDX_W + 1)'(SLOTS)))
		else $error("scan address past table");

	a_fired_only_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && (fired_id != '0) |-> (cmd_q == CMD_HANDLE))
		else $error("fired id outside handle");
`endif

endmodule
